// ===== src/ppc_pkg.sv =====
package ppc_pkg;

    localparam int unsigned VALUE_W         = 24;
    localparam int unsigned DIGIT_W         = 4;
    localparam int unsigned NUM_DIGITS      = 8;
    localparam int unsigned NUM_PAIRS       = NUM_DIGITS / 2;
    localparam int unsigned LEN_W           = 3;
    localparam int unsigned QUOT_W          = 11;
    localparam int unsigned HALF_W          = 14;
    localparam int unsigned PAIR_W          = 7;
    localparam int unsigned SIEVE_DEPTH_DEF = 1048576;

    localparam logic [HALF_W-1:0]  TEN_K   = 14'd10000;
    localparam logic [PAIR_W-1:0]  HUNDRED = 7'd100;
    localparam logic [DIGIT_W-1:0] TEN     = 4'd10;

    // floor(v / d) = (v * m) >> s over the whole input range of each step
    localparam logic [24:0]        RECIP_10K    = 25'd27487791;
    localparam int unsigned        RECIP_10K_SH = 38;
    localparam logic [HALF_W-1:0]  RECIP_100    = 14'd10486;
    localparam int unsigned        RECIP_100_SH = 20;
    localparam logic [7:0]         RECIP_10     = 8'd205;
    localparam int unsigned        RECIP_10_SH  = 11;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

    typedef struct packed {
        logic   en;
        value_t addr;
    } map_rd_t;

    localparam value_t POW10 [NUM_DIGITS] = '{
        24'd1, 24'd10, 24'd100, 24'd1000,
        24'd10000, 24'd100000, 24'd1000000, 24'd10000000
    };

    function automatic logic [QUOT_W-1:0] div_10k(value_t v);
        logic [VALUE_W+25-1:0] p;
        p = v * RECIP_10K;
        return p[RECIP_10K_SH+QUOT_W-1:RECIP_10K_SH];
    endfunction

    function automatic logic [HALF_W-1:0] rem_10k(value_t v, logic [QUOT_W-1:0] q);
        value_t p;
        p = value_t'(q) * value_t'(TEN_K);
        p = v - p;
        return p[HALF_W-1:0];
    endfunction

    function automatic logic [PAIR_W-1:0] div_100(logic [HALF_W-1:0] x);
        logic [2*HALF_W-1:0] p;
        p = x * RECIP_100;
        return p[RECIP_100_SH+PAIR_W-1:RECIP_100_SH];
    endfunction

    function automatic logic [PAIR_W-1:0] rem_100(logic [HALF_W-1:0] x,
                                                  logic [PAIR_W-1:0] h);
        logic [HALF_W-1:0] p;
        p = HALF_W'(h) * HALF_W'(HUNDRED);
        p = x - p;
        return p[PAIR_W-1:0];
    endfunction

    function automatic logic [DIGIT_W-1:0] div_10(logic [PAIR_W-1:0] x);
        logic [PAIR_W+8-1:0] p;
        p = x * RECIP_10;
        return p[RECIP_10_SH+DIGIT_W-1:RECIP_10_SH];
    endfunction

    function automatic logic [DIGIT_W-1:0] rem_10(logic [PAIR_W-1:0] x,
                                                  logic [DIGIT_W-1:0] t);
        logic [PAIR_W-1:0] p;
        p = PAIR_W'(t) * PAIR_W'(TEN);
        p = x - p;
        return p[DIGIT_W-1:0];
    endfunction

    // number of decimal digits minus one
    function automatic logic [LEN_W-1:0] digit_len_m1(value_t v);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int k = 1; k < NUM_DIGITS; k++) begin
            if (v >= POW10[k]) begin
                n = n + 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic pal_check(digits_t d, logic [LEN_W-1:0] nm1);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if ((LEN_W'(k) <= nm1) && (d[LEN_W'(k)] != d[nm1 - LEN_W'(k)])) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

// ===== src/ppc_value_if.sv =====
interface ppc_value_if;
    import ppc_pkg::*;

    logic   valid;
    logic   ready;
    value_t value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);

endinterface

// ===== src/ppc_result_if.sv =====
interface ppc_result_if;

    logic valid;
    logic ready;
    logic is_prime;
    logic is_palindrome;
    logic out_of_range;

    modport source (
        output valid, output is_prime, output is_palindrome, output out_of_range,
        input ready
    );
    modport sink (
        input valid, input is_prime, input is_palindrome, input out_of_range,
        output ready
    );

endinterface

// ===== src/ppc_sieve.sv =====
module ppc_sieve #(
    parameter int unsigned SIEVE_DEPTH = ppc_pkg::SIEVE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ppc_pkg::map_rd_t map_rd,
    output logic            map_bit,
    output logic            done
);
    import ppc_pkg::*;

    localparam int unsigned AW      = $clog2(SIEVE_DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW+1)'(SIEVE_DEPTH);
    localparam logic [AW:0] LAST    = (AW+1)'(SIEVE_DEPTH - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_READ  = 5'b00010,
        S_TEST  = 5'b00100,
        S_MARK  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW:0]     cnt_reg, cnt_next;
    logic [AW:0]     sq_reg, sq_next;
    logic [AW-1:0]   i_reg, i_next;
    logic            we;
    logic            wr_bit;
    logic [AW:0]     step;
    logic [AW:0]     sq_adv;
    logic [AW-1:0]   i_adv;
    logic            test_bit_reg;
    logic            map_bit_reg;
    logic            map_mem [SIEVE_DEPTH];

    assign step   = cnt_reg + {1'b0, i_reg};
    assign sq_adv = sq_reg + {i_reg, 1'b1};
    assign i_adv  = i_reg + 1'b1;
    assign wr_bit = (state_reg == S_MARK);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sq_next    = sq_reg;
        i_next     = i_reg;
        we         = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                if (cnt_reg == LAST)
                begin
                    state_next = S_READ;
                    i_next     = AW'(2);
                    sq_next    = (AW+1)'(4);
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_READ:
            begin
                if (sq_reg >= DEPTH_W)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (test_bit_reg)
                begin
                    i_next     = i_adv;
                    sq_next    = sq_adv;
                    state_next = S_READ;
                end
                else
                begin
                    cnt_next   = sq_reg;
                    state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                we = 1'b1;
                if (step >= DEPTH_W)
                begin
                    i_next     = i_adv;
                    sq_next    = sq_adv;
                    state_next = S_READ;
                end
                else
                begin
                    cnt_next = step;
                end
            end
            S_DONE:
            begin
                state_next = S_DONE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            sq_reg    <= '0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sq_reg    <= sq_next;
            i_reg     <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            map_mem[cnt_reg[AW-1:0]] <= wr_bit;
        end
        test_bit_reg <= map_mem[i_reg];
        if (map_rd.en)
        begin
            map_bit_reg <= map_mem[map_rd.addr[AW-1:0]];
        end
    end

    assign map_bit = map_bit_reg;
    assign done    = (state_reg == S_DONE);

`ifndef SYNTHESIS
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> done)
        else $error("sieve done dropped");

    a_no_write_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> !we)
        else $error("map written after sieve done");

    a_done_past_root: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (sq_reg >= DEPTH_W))
        else $error("sieve done before square passed depth");
`endif

endmodule

// ===== src/ppc_query_pipe.sv =====
module ppc_query_pipe #(
    parameter int unsigned SIEVE_DEPTH = ppc_pkg::SIEVE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    ppc_value_if.sink        query,
    ppc_result_if.source     result,
    output ppc_pkg::map_rd_t map_rd,
    input  logic             map_bit,
    input  logic             sieve_done
);
    import ppc_pkg::*;

    localparam int unsigned      NUM_STAGES = 7;
    localparam logic [VALUE_W:0] DEPTH_X    = (VALUE_W+1)'(SIEVE_DEPTH);

    typedef struct packed {
        logic [LEN_W-1:0] len_m1;
        logic             oor;
        logic             prime;
    } flags_t;

    logic [NUM_STAGES-1:0]               v_reg, v_next, en;
    logic                                accept;
    logic                                in_oor;
    flags_t                              f_reg [NUM_STAGES-1];
    value_t                              val0_reg;
    logic [QUOT_W-1:0]                   q0_reg;
    logic [HALF_W-1:0]                   a1_reg, b1_reg, a2_reg, b2_reg;
    logic [PAIR_W-1:0]                   ha2_reg, hb2_reg;
    logic [NUM_PAIRS-1:0][PAIR_W-1:0]    pair3_reg, pair4_reg;
    logic [NUM_PAIRS-1:0][DIGIT_W-1:0]   tens4_reg;
    digits_t                             dig5_reg;
    logic                                prime6_reg, pal6_reg, oor6_reg;

    always_comb
    begin
        en[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || result.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign query.ready = sieve_done && en[0];
    assign accept      = query.valid && query.ready;
    assign in_oor      = ({1'b0, query.value} >= DEPTH_X);

    assign map_rd.en   = en[0];
    assign map_rd.addr = query.value;

    always_comb
    begin
        v_next[0] = en[0] ? accept : v_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            val0_reg <= query.value;
            q0_reg   <= div_10k(query.value);
            f_reg[0] <= '{len_m1: digit_len_m1(query.value),
                          oor:    in_oor,
                          prime:  (query.value >= VALUE_W'(2)) && !in_oor};
        end
        if (en[1])
        begin
            a1_reg   <= HALF_W'(q0_reg);
            b1_reg   <= rem_10k(val0_reg, q0_reg);
            f_reg[1] <= '{len_m1: f_reg[0].len_m1,
                          oor:    f_reg[0].oor,
                          prime:  f_reg[0].prime && !map_bit};
        end
        if (en[2])
        begin
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            ha2_reg  <= div_100(a1_reg);
            hb2_reg  <= div_100(b1_reg);
            f_reg[2] <= f_reg[1];
        end
        if (en[3])
        begin
            pair3_reg <= {ha2_reg, rem_100(a2_reg, ha2_reg),
                          hb2_reg, rem_100(b2_reg, hb2_reg)};
            f_reg[3]  <= f_reg[2];
        end
        if (en[4])
        begin
            pair4_reg <= pair3_reg;
            for (int k = 0; k < NUM_PAIRS; k++)
            begin
                tens4_reg[k] <= div_10(pair3_reg[k]);
            end
            f_reg[4] <= f_reg[3];
        end
        if (en[5])
        begin
            for (int k = 0; k < NUM_PAIRS; k++)
            begin
                dig5_reg[2*k+1] <= tens4_reg[k];
                dig5_reg[2*k]   <= rem_10(pair4_reg[k], tens4_reg[k]);
            end
            f_reg[5] <= f_reg[4];
        end
        if (en[6])
        begin
            prime6_reg <= f_reg[5].prime;
            pal6_reg   <= pal_check(dig5_reg, f_reg[5].len_m1);
            oor6_reg   <= f_reg[5].oor;
        end
    end

    assign result.valid         = v_reg[NUM_STAGES-1];
    assign result.is_prime      = prime6_reg;
    assign result.is_palindrome = pal6_reg;
    assign result.out_of_range  = oor6_reg;

`ifndef SYNTHESIS
    a_empty_before_sieve: assert property (@(posedge clk) disable iff (!rst_n)
        !sieve_done |-> (v_reg == '0))
        else $error("beat in flight before sieve done");

    a_result_after_sieve: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> sieve_done)
        else $error("result before sieve done");

    a_prime_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.is_prime) |-> !result.out_of_range)
        else $error("prime reported out of range");
`endif

endmodule

// ===== src/palindromic_prime_classifier.sv =====
// channel  dir  beat payload                              handshake
// query    in   value[23:0]                               valid / ready
// result   out  is_prime, is_palindrome, out_of_range     valid / ready
//
// After reset, query.ready stays low while the map is built: a clearing pass over
// all SIEVE_DEPTH entries, then the sieve, with one map write per cycle while
// clearing or marking, through the single write port.
// Then one beat per cycle while results are taken. A stalled result holds each
// occupied stage with no empty stage after it; other stages advance and fill.
module palindromic_prime_classifier #(
    parameter int unsigned SIEVE_DEPTH = ppc_pkg::SIEVE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ppc_value_if.sink    query,
    ppc_result_if.source result
);
    import ppc_pkg::*;

    map_rd_t map_rd;
    logic    map_bit;
    logic    sieve_done;

    ppc_sieve #(
        .SIEVE_DEPTH (SIEVE_DEPTH)
    ) u_sieve (
        .clk     (clk),
        .rst_n   (rst_n),
        .map_rd  (map_rd),
        .map_bit (map_bit),
        .done    (sieve_done)
    );

    ppc_query_pipe #(
        .SIEVE_DEPTH (SIEVE_DEPTH)
    ) u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .query      (query),
        .result     (result),
        .map_rd     (map_rd),
        .map_bit    (map_bit),
        .sieve_done (sieve_done)
    );

endmodule
